/* rtl/hcbd_pkg.sv */
// shared types, constants and reset values for the chunked body decoder
// depends on nothing; used by hcbd_step and http_chunked_body_decoder_core

package hcbd_pkg;

	// width of the chunk size register and of the saturating length counter
	localparam int SIZE_BITS = 32;
	localparam int LEN_BITS  = 32;

	// fixed field widths of the result request
	localparam int BYTE_W = 8;
	localparam int ERR_W  = 3;
	localparam int DLEN_W = 32;
	// out_valid travels on tuser, the rest on tdata
	localparam int TDATA_BITS  = BYTE_W + 1 + ERR_W + DLEN_W;
	localparam int TDATA_OUT_W = ((TDATA_BITS + 7) / 8) * 8;

	// character codes
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;

	// error codes
	typedef enum logic [ERR_W-1:0] {
		ERR_NONE      = 3'd0,
		ERR_TRUNC     = 3'd1,
		ERR_BAD_SIZE  = 3'd2,
		ERR_BAD_TERM  = 3'd3,
		ERR_TRAILER   = 3'd4
	} err_t;

	// decoder phase, one-hot
	typedef enum logic [6:0] {
		PH_SIZE  = 7'b0000001,
		PH_DATA  = 7'b0000010,
		PH_DCR   = 7'b0000100,
		PH_DLF   = 7'b0001000,
		PH_TRAIL = 7'b0010000,
		PH_DONE  = 7'b0100000,
		PH_ERR   = 7'b1000000
	} phase_t;

	typedef struct packed {
		phase_t               phase;
		logic [SIZE_BITS-1:0] size_accum;
		logic [SIZE_BITS-1:0] bytes_left;
		logic                 digit_seen;
		logic                 digits_closed;
		logic                 cr_pending;
		logic                 line_empty;
		logic [LEN_BITS-1:0]  total_count;
		err_t                 error_latch;
	} state_t;

	typedef struct packed {
		logic [DLEN_W-1:0] decoded_length;
		err_t              error_code;
		logic              done_res;
		logic              out_valid;
		logic [BYTE_W-1:0] out_byte;
	} result_t;

	localparam state_t STATE_RESET = '{
		phase:         PH_SIZE,
		size_accum:    '0,
		bytes_left:    '0,
		digit_seen:    1'b0,
		digits_closed: 1'b0,
		cr_pending:    1'b0,
		line_empty:    1'b1,
		total_count:   '0,
		error_latch:   ERR_NONE
	};

endpackage

/* rtl/hcbd_step.sv */
// next-state and result logic of the chunked body decoder for one byte
// depends on hcbd_pkg

module hcbd_step (
	input  hcbd_pkg::state_t                 cur,
	input  logic [hcbd_pkg::BYTE_W-1:0]      in_byte,
	input  logic                             end_of_input,
	output hcbd_pkg::state_t                 nxt,
	output hcbd_pkg::result_t                res
);

	function automatic logic is_hex(input logic [hcbd_pkg::BYTE_W-1:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_val(input logic [hcbd_pkg::BYTE_W-1:0] c);
		logic [hcbd_pkg::BYTE_W-1:0] d;
		d = 8'd0;
		if (c >= "0" && c <= "9") begin
			d = c - 8'h30;
		end else if (c >= "a" && c <= "f") begin
			d = c - 8'h57;
		end else begin
			d = c - 8'h37;
		end
		return d[3:0];
	endfunction

	function automatic void clear_line(inout hcbd_pkg::state_t s);
		s.size_accum    = '0;
		s.digit_seen    = 1'b0;
		s.digits_closed = 1'b0;
		s.cr_pending    = 1'b0;
		s.line_empty    = 1'b1;
	endfunction

	// one content byte of a size line
	function automatic void size_content(inout hcbd_pkg::state_t s,
			input logic [hcbd_pkg::BYTE_W-1:0] c);
		if (!s.digits_closed) begin
			if (is_hex(c)) begin
				if (s.size_accum[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
					s.error_latch = hcbd_pkg::ERR_BAD_SIZE;
					s.phase       = hcbd_pkg::PH_ERR;
				end else begin
					s.size_accum = {s.size_accum[hcbd_pkg::SIZE_BITS-5:0], hex_val(c)};
					s.digit_seen = 1'b1;
				end
			end else if (!s.digit_seen && (c == hcbd_pkg::CH_SP || c == hcbd_pkg::CH_TAB)) begin
				s.digits_closed = 1'b0;
			end else begin
				s.digits_closed = 1'b1;
			end
		end
	endfunction

	hcbd_pkg::state_t s;
	logic [hcbd_pkg::BYTE_W-1:0] ob;
	logic ov;
	logic [hcbd_pkg::SIZE_BITS-1:0] left_dec;

	assign left_dec = cur.bytes_left - hcbd_pkg::SIZE_BITS'(1);

	always_comb begin
		s  = cur;
		ob = '0;
		ov = 1'b0;
		case (cur.phase)
			hcbd_pkg::PH_SIZE: begin
				if (in_byte == hcbd_pkg::CH_LF && cur.cr_pending) begin
					if (!cur.digit_seen) begin
						s.error_latch = hcbd_pkg::ERR_BAD_SIZE;
						s.phase       = hcbd_pkg::PH_ERR;
					end else begin
						if (cur.size_accum == '0) begin
							clear_line(s);
							s.phase = hcbd_pkg::PH_TRAIL;
						end else begin
							s.bytes_left = cur.size_accum;
							s.phase      = hcbd_pkg::PH_DATA;
						end
						s.cr_pending = 1'b0;
					end
				end else begin
					// a lone cr is ordinary line content
					if (cur.cr_pending) begin
						size_content(s, hcbd_pkg::CH_CR);
						s.cr_pending = 1'b0;
					end
					if (s.phase != hcbd_pkg::PH_ERR) begin
						if (in_byte == hcbd_pkg::CH_CR) begin
							s.cr_pending = 1'b1;
						end else begin
							size_content(s, in_byte);
						end
					end
				end
			end
			hcbd_pkg::PH_DATA: begin
				ob = in_byte;
				ov = 1'b1;
				if (cur.total_count != '1) begin
					s.total_count = cur.total_count + hcbd_pkg::LEN_BITS'(1);
				end
				s.bytes_left = left_dec;
				if (left_dec == '0) begin
					s.phase = hcbd_pkg::PH_DCR;
				end
			end
			hcbd_pkg::PH_DCR: begin
				if (in_byte == hcbd_pkg::CH_CR) begin
					s.phase = hcbd_pkg::PH_DLF;
				end else begin
					s.error_latch = hcbd_pkg::ERR_BAD_TERM;
					s.phase       = hcbd_pkg::PH_ERR;
				end
			end
			hcbd_pkg::PH_DLF: begin
				if (in_byte == hcbd_pkg::CH_LF) begin
					clear_line(s);
					s.phase = hcbd_pkg::PH_SIZE;
				end else begin
					s.error_latch = hcbd_pkg::ERR_BAD_TERM;
					s.phase       = hcbd_pkg::PH_ERR;
				end
			end
			hcbd_pkg::PH_TRAIL: begin
				if (in_byte == hcbd_pkg::CH_LF && cur.cr_pending) begin
					if (cur.line_empty) begin
						s.phase = hcbd_pkg::PH_DONE;
					end else begin
						clear_line(s);
					end
					s.cr_pending = 1'b0;
				end else begin
					if (cur.cr_pending) begin
						s.line_empty = 1'b0;
					end
					if (in_byte == hcbd_pkg::CH_CR) begin
						s.cr_pending = 1'b1;
					end else begin
						s.cr_pending = 1'b0;
						s.line_empty = 1'b0;
					end
				end
			end
			default: begin
				s = cur;
			end
		endcase

		// input ended before the body did
		if (end_of_input) begin
			case (s.phase)
				hcbd_pkg::PH_SIZE: begin
					s.error_latch = hcbd_pkg::ERR_TRUNC;
					s.phase       = hcbd_pkg::PH_ERR;
				end
				hcbd_pkg::PH_DATA, hcbd_pkg::PH_DCR, hcbd_pkg::PH_DLF: begin
					s.error_latch = hcbd_pkg::ERR_BAD_TERM;
					s.phase       = hcbd_pkg::PH_ERR;
				end
				hcbd_pkg::PH_TRAIL: begin
					s.error_latch = hcbd_pkg::ERR_TRAILER;
					s.phase       = hcbd_pkg::PH_ERR;
				end
				default: begin
					s.phase = s.phase;
				end
			endcase
		end
	end

	assign nxt                = s;
	assign res.out_byte       = ob;
	assign res.out_valid      = ov;
	assign res.done_res       = (s.phase == hcbd_pkg::PH_DONE);
	assign res.error_code     = s.error_latch;
	assign res.decoded_length = hcbd_pkg::DLEN_W'(s.total_count);

endmodule

/* rtl/http_chunked_body_decoder_core.sv */
// top level of the http/1.1 chunked transfer body decoder
// depends on hcbd_pkg and hcbd_step

// Decodes a chunked http body one byte per request. Each input request carries one raw
// byte in s_tdata and the end-of-input mark in s_tlast. Every input request yields exactly
// one output request holding the payload byte (its valid flag on m_tuser), the sticky done
// flag, the sticky error code and the saturating decoded length. The block takes one byte per
// cycle while m_tready stays high: an input register feeds the combinational state update,
// whose result lands in an output register; an accepted byte passes through the input
// register and then the output register to m_tvalid. Backpressure on the output stalls the
// input register, which in turn drops s_tready only once both registers hold a request.
// Once done or an error is reached, further bytes are ignored and the latched status is
// repeated with the valid flag low.

module http_chunked_body_decoder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [hcbd_pkg::BYTE_W-1:0]         s_tdata,  // [7:0] in_byte
	input  logic                                s_tlast,  // end_of_input
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] out_byte, [8] done_res, [11:9] error_code,
	// [43:12] decoded_length, [47:44] zero
	output logic [hcbd_pkg::TDATA_OUT_W-1:0]    m_tdata,
	output logic                                m_tuser   // out_valid
);

	// input register
	logic                        valid_s1;
	logic [hcbd_pkg::BYTE_W-1:0] byte_s1;
	logic                        last_s1;

	// output register
	logic                        valid_s2;
	hcbd_pkg::result_t           res_s2;

	// decoder state
	hcbd_pkg::state_t            state_q;
	hcbd_pkg::state_t            state_nxt;
	hcbd_pkg::result_t           res_nxt;

	logic adv;    // output register can take a new result
	logic fire;   // stage 1 request moves into the output register

	assign adv      = !valid_s2 || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	hcbd_step u_step (
		.cur          (state_q),
		.in_byte      (byte_s1),
		.end_of_input (last_s1),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= hcbd_pkg::STATE_RESET;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				state_q <= state_nxt;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (fire) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = hcbd_pkg::TDATA_OUT_W'({res_s2.decoded_length, res_s2.error_code,
		res_s2.done_res, res_s2.out_byte});
	assign m_tuser  = res_s2.out_valid;

endmodule

/* tb/sv/http_chunked_body_decoder_core_test.sv */
// self-checking testbench for http_chunked_body_decoder_core: one long chunked body, random gaps
// depends on hcbd_pkg and the decoder rtl; a scoreboard class predicts every result request

module http_chunked_body_decoder_core_test;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int BODY_ITEMS  = 1880;
	localparam int HOLD_CYCLES = 150;

	// how the single body of the run is closed; reset happens once, so only one ending
	// fits in a run and the seed picks it
	typedef enum int {
		END_CLEAN,
		END_CUT_SIZE,
		END_CUT_DATA,
		END_BAD_TERM,
		END_WIDE_SIZE,
		END_NO_DIGITS,
		END_CUT_TRAILER,
		END_HUGE_CHUNK
	} ending_t;

	// tracks the decoder state byte by byte and holds the expected result requests
	class chunk_body_scoreboard;
		hcbd_pkg::phase_t               ph;
		logic [hcbd_pkg::SIZE_BITS-1:0] size_acc;
		logic [hcbd_pkg::SIZE_BITS-1:0] remaining;
		bit                             got_digit;
		bit                             ext_started;
		bit                             cr_seen;
		bit                             blank_line;
		logic [hcbd_pkg::LEN_BITS-1:0]  payload_count;
		hcbd_pkg::err_t                 err;
		hcbd_pkg::result_t              awaited[$];
		int unsigned                    mismatches;
		int unsigned                    checked;

		function new();
			ph = hcbd_pkg::PH_SIZE;
			remaining = '0;
			payload_count = '0;
			err = hcbd_pkg::ERR_NONE;
			mismatches = 0;
			checked = 0;
			start_line();
		endfunction

		function void start_line();
			size_acc = '0;
			got_digit = 1'b0;
			ext_started = 1'b0;
			cr_seen = 1'b0;
			blank_line = 1'b1;
		endfunction

		function void abort(hcbd_pkg::err_t code);
			err = code;
			ph = hcbd_pkg::PH_ERR;
		endfunction

		function int hex_digit(logic [7:0] c);
			// ascii offsets of '0', 'a' - 10 and 'A' - 10
			if (c >= "0" && c <= "9") return int'(c) - 48;
			if (c >= "a" && c <= "f") return int'(c) - 87;
			if (c >= "A" && c <= "F") return int'(c) - 55;
			return -1;
		endfunction

		// one byte of size line content, cr/lf framing already stripped
		function void size_char(logic [7:0] c);
			int v;
			v = hex_digit(c);
			if (ext_started) return;
			if (v >= 0) begin
				// next digit would push bits out of the size register
				if (size_acc[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
					abort(hcbd_pkg::ERR_BAD_SIZE);
					return;
				end
				size_acc = {size_acc[hcbd_pkg::SIZE_BITS-5:0], 4'(v)};
				got_digit = 1'b1;
			end else if (!got_digit && (c == hcbd_pkg::CH_SP || c == hcbd_pkg::CH_TAB)) begin
				// leading blank, skipped
			end else begin
				ext_started = 1'b1;
			end
		endfunction

		function void size_line_byte(logic [7:0] c);
			if (c == hcbd_pkg::CH_LF && cr_seen) begin
				if (!got_digit) begin
					abort(hcbd_pkg::ERR_BAD_SIZE);
					return;
				end
				if (size_acc == '0) begin
					start_line();
					ph = hcbd_pkg::PH_TRAIL;
				end else begin
					remaining = size_acc;
					ph = hcbd_pkg::PH_DATA;
				end
				cr_seen = 1'b0;
				return;
			end
			// a cr without lf behind it is plain content
			if (cr_seen) begin
				size_char(hcbd_pkg::CH_CR);
				cr_seen = 1'b0;
				if (ph == hcbd_pkg::PH_ERR) return;
			end
			if (c == hcbd_pkg::CH_CR) cr_seen = 1'b1;
			else size_char(c);
		endfunction

		function void trailer_char(logic [7:0] c);
			if (c == hcbd_pkg::CH_LF && cr_seen) begin
				if (blank_line) ph = hcbd_pkg::PH_DONE;
				else start_line();
				cr_seen = 1'b0;
				return;
			end
			if (cr_seen) blank_line = 1'b0;
			if (c == hcbd_pkg::CH_CR) begin
				cr_seen = 1'b1;
			end else begin
				cr_seen = 1'b0;
				blank_line = 1'b0;
			end
		endfunction

		// accepted input request: advance the state and queue the result it causes
		function void note_request(logic [7:0] c, bit last);
			hcbd_pkg::result_t r;
			r = '0;
			case (ph)
				hcbd_pkg::PH_SIZE: size_line_byte(c);
				hcbd_pkg::PH_DATA: begin
					r.out_byte = c;
					r.out_valid = 1'b1;
					if (payload_count != '1) payload_count++;
					remaining--;
					if (remaining == '0) ph = hcbd_pkg::PH_DCR;
				end
				hcbd_pkg::PH_DCR: begin
					if (c == hcbd_pkg::CH_CR) ph = hcbd_pkg::PH_DLF;
					else abort(hcbd_pkg::ERR_BAD_TERM);
				end
				hcbd_pkg::PH_DLF: begin
					if (c == hcbd_pkg::CH_LF) begin
						start_line();
						ph = hcbd_pkg::PH_SIZE;
					end else begin
						abort(hcbd_pkg::ERR_BAD_TERM);
					end
				end
				hcbd_pkg::PH_TRAIL: trailer_char(c);
				default: begin
				end
			endcase
			if (last) begin
				case (ph)
					hcbd_pkg::PH_SIZE: abort(hcbd_pkg::ERR_TRUNC);
					hcbd_pkg::PH_DATA, hcbd_pkg::PH_DCR, hcbd_pkg::PH_DLF:
						abort(hcbd_pkg::ERR_BAD_TERM);
					hcbd_pkg::PH_TRAIL: abort(hcbd_pkg::ERR_TRAILER);
					default: begin
					end
				endcase
			end
			r.done_res = (ph == hcbd_pkg::PH_DONE);
			r.error_code = err;
			r.decoded_length = hcbd_pkg::DLEN_W'(payload_count);
			awaited.insert(awaited.size(), r);
		endfunction

		function void flag_field(string name, longint unsigned want, longint unsigned got);
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		endfunction

		function void check_result(logic [hcbd_pkg::TDATA_OUT_W-1:0] word, logic flag);
			logic [hcbd_pkg::BYTE_W-1:0] got_byte;
			logic                        got_done;
			logic [hcbd_pkg::ERR_W-1:0]  got_err;
			logic [hcbd_pkg::DLEN_W-1:0] got_len;
			hcbd_pkg::result_t           want;
			{got_len, got_err, got_done, got_byte} = word[hcbd_pkg::TDATA_BITS-1:0];
			checked++;
			if (awaited.size() == 0) begin
				$display("%0t: result request with none expected, actual %0h", $time, word);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (got_byte !== want.out_byte)
				flag_field("out_byte", want.out_byte, got_byte);
			if (flag !== want.out_valid)
				flag_field("out_valid", want.out_valid, flag);
			if (got_done !== want.done_res)
				flag_field("done_res", want.done_res, got_done);
			if (got_err !== want.error_code)
				flag_field("error_code", want.error_code, got_err);
			if (got_len !== want.decoded_length)
				flag_field("decoded_length", want.decoded_length, got_len);
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [hcbd_pkg::BYTE_W-1:0]      s_tdata;
	logic                             s_tlast;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [hcbd_pkg::TDATA_OUT_W-1:0] m_tdata;
	logic                             m_tuser;

	chunk_body_scoreboard board = new();
	// body bytes in send order, end-of-input mark in bit 8
	logic [8:0]  feed[$];
	// set while the receiver holds off, so the sender keeps offering without gaps
	bit          hold_active;
	int unsigned cycle_count;

	http_chunked_body_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void push_byte(logic [7:0] b, bit last = 1'b0);
		feed.insert(feed.size(), {last, b});
	endfunction

	// random line content that never forms cr lf, so the line ends only where intended;
	// prev is the byte queued just before
	function automatic void push_noise(int count, logic [7:0] prev);
		logic [7:0] b;
		int i;
		for (i = 0; i < count; i++) begin
			b = 8'($urandom);
			if (prev == hcbd_pkg::CH_CR && b == hcbd_pkg::CH_LF) b = "x";
			push_byte(b);
			prev = b;
		end
	endfunction

	// hex digits of a size, most significant first, letters in random case
	function automatic void push_size_digits(logic [hcbd_pkg::SIZE_BITS-1:0] sz, int digits);
		logic [3:0] nib;
		int i;
		for (i = digits - 1; i >= 0; i--) begin
			nib = 4'(sz >> (4 * i));
			if (nib < 4'd10) push_byte(8'h30 + nib);
			else push_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10);
		end
	endfunction

	// size line with optional leading blanks, leading zeros and extension
	function automatic void push_size_line(logic [hcbd_pkg::SIZE_BITS-1:0] sz);
		int digits;
		int i;
		logic [7:0] opener;
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
			push_byte($urandom_range(0, 1) ? hcbd_pkg::CH_SP : hcbd_pkg::CH_TAB);
		digits = 1;
		for (i = 1; i < hcbd_pkg::SIZE_BITS / 4; i++)
			if ((sz >> (4 * i)) != '0) digits = i + 1;
		if ($urandom_range(0, 7) == 0) digits += $urandom_range(1, 3);
		push_size_digits(sz, digits);
		if ($urandom_range(0, 3) == 0) begin
			// the extension opens with a non-hex byte, a lone cr or a lone lf among them
			case ($urandom_range(0, 4))
				0: opener = hcbd_pkg::CH_SP;
				1: opener = hcbd_pkg::CH_TAB;
				2: opener = hcbd_pkg::CH_CR;
				3: opener = hcbd_pkg::CH_LF;
				default: opener = ";";
			endcase
			push_byte(opener);
			push_noise($urandom_range(0, 6), opener);
		end
		push_byte(hcbd_pkg::CH_CR);
		push_byte(hcbd_pkg::CH_LF);
	endfunction

	function automatic void push_chunk(logic [hcbd_pkg::SIZE_BITS-1:0] sz);
		push_size_line(sz);
		repeat (sz) push_byte(8'($urandom));
		push_byte(hcbd_pkg::CH_CR);
		push_byte(hcbd_pkg::CH_LF);
	endfunction

	// non-empty trailer lines, each closed by cr lf
	function automatic void push_trailer_lines(int lines);
		repeat (lines) begin
			push_noise($urandom_range(1, 12), hcbd_pkg::CH_LF);
			push_byte(hcbd_pkg::CH_CR);
			push_byte(hcbd_pkg::CH_LF);
		end
	endfunction

	// offers one input request and waits for its handshake
	task automatic send_request(logic [8:0] item, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= item[7:0];
		s_tlast  <= item[8];
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		board.note_request(item[7:0], item[8]);
	endtask

	initial begin : stimulus
		logic [7:0] extremes[10];
		logic [hcbd_pkg::SIZE_BITS-1:0] sz;
		ending_t ending;
		int pick;
		int i;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;

		// directed opening: blanks before the digits, a leading zero, upper case hex,
		// an extension holding a lone cr and a lone lf, then extreme payload values
		push_byte(hcbd_pkg::CH_SP);
		push_byte(hcbd_pkg::CH_TAB);
		push_byte("0");
		push_byte("A");
		push_byte(";");
		push_byte(hcbd_pkg::CH_CR);
		push_byte("x");
		push_byte(hcbd_pkg::CH_LF);
		push_byte(hcbd_pkg::CH_CR);
		push_byte(hcbd_pkg::CH_LF);
		extremes = '{8'h00, 8'hff, hcbd_pkg::CH_CR, hcbd_pkg::CH_LF, 8'h55, 8'haa, 8'h80,
			8'h7f, 8'h01, 8'hfe};
		foreach (extremes[k]) push_byte(extremes[k]);
		push_byte(hcbd_pkg::CH_CR);
		push_byte(hcbd_pkg::CH_LF);

		// well-formed chunks with random content, mostly small, some larger
		while (feed.size() < BODY_ITEMS)
			push_chunk($urandom_range(0, 9) == 0 ? $urandom_range(40, 200) : $urandom_range(1, 24));

		pick = $urandom_range(0, 11);
		ending = (pick < 5) ? END_CLEAN : ending_t'(pick - 4);
		case (ending)
			END_CLEAN: begin
				// zero chunk, trailers, empty line; end of input on the last lf or not at all
				push_size_line('0);
				push_trailer_lines($urandom_range(0, 3));
				push_byte(hcbd_pkg::CH_CR);
				push_byte(hcbd_pkg::CH_LF, 1'($urandom_range(0, 1)));
			end
			END_CUT_SIZE: begin
				push_byte("1");
				push_byte(hcbd_pkg::CH_CR, 1'b1);
			end
			END_CUT_DATA: begin
				push_size_line(5);
				repeat (3) push_byte(8'($urandom));
				push_byte(8'($urandom), 1'b1);
			end
			END_BAD_TERM: begin
				push_size_line(3);
				repeat (3) push_byte(8'($urandom));
				if ($urandom_range(0, 1)) push_byte(hcbd_pkg::CH_CR);
				push_byte("x");
			end
			END_WIDE_SIZE: begin
				// a full register of digits with a non-zero top, then one digit too many
				sz = hcbd_pkg::SIZE_BITS'({$urandom, $urandom});
				sz[hcbd_pkg::SIZE_BITS-1 -: 4] = 4'($urandom_range(1, 15));
				push_size_digits(sz, hcbd_pkg::SIZE_BITS / 4);
				push_size_digits(hcbd_pkg::SIZE_BITS'($urandom), 1);
				push_byte(hcbd_pkg::CH_CR);
				push_byte(hcbd_pkg::CH_LF);
			end
			END_NO_DIGITS: begin
				case ($urandom_range(0, 2))
					0: push_byte(hcbd_pkg::CH_SP);
					1: begin
						push_byte(";");
						push_noise($urandom_range(0, 4), ";");
					end
					default: begin
						// lone cr before any digit ends the digit field
						push_byte(hcbd_pkg::CH_CR);
						push_byte("7");
					end
				endcase
				push_byte(hcbd_pkg::CH_CR);
				push_byte(hcbd_pkg::CH_LF);
			end
			END_CUT_TRAILER: begin
				push_size_line('0);
				push_trailer_lines($urandom_range(0, 2));
				push_noise($urandom_range(1, 5), hcbd_pkg::CH_LF);
				push_byte(8'($urandom), 1'b1);
			end
			default: begin
				// largest size the register holds, cut short inside the data
				push_size_line('1);
				repeat (30) push_byte(8'($urandom));
				push_byte(8'($urandom), 1'b1);
			end
		endcase

		// bytes after the end are ignored but still each give a result request
		repeat ($urandom_range(8, 20)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
		push_byte(8'($urandom), 1'b1);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// every fourth stretch of 128 requests goes without gaps
		for (i = 0; i < feed.size(); i++)
			send_request(feed[i], (hold_active || (i / 128) % 4 == 3) ? 0 : idle_cycles());
		s_tvalid <= 1'b0;

		while (board.awaited.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.mismatches == 0 && board.awaited.size() == 0) begin
			$display("http_chunked_body_decoder_core_test passed");
		end else begin
			$display("http_chunked_body_decoder_core_test failed");
		end
		$finish;
	end

	// result side: random stalls, one long hold-off so the block fills and stalls its input
	initial begin : receiver
		int stall;
		bit held;
		stall = 0;
		held = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) board.check_result(m_tdata, m_tuser);
			if (!held && board.checked >= 400) begin
				held = 1'b1;
				hold_active = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
				m_tready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ((board.checked / 128) % 4 != 1) stall = idle_cycles();
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("http_chunked_body_decoder_core_test failed");
		$finish;
	end

endmodule
